// File: design/ps2kbd_pkg.sv
// Shared types and constants of the PS/2 keyboard frame and key decoder.
package ps2kbd_pkg;

    // Event codes on the input channel
    localparam logic CMD_EDGE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Frame and gap limits
    localparam logic [9:0] TIMEOUT_RESET = 10'd250;
    localparam logic [3:0] FRAME_EDGES   = 4'd11;
    localparam logic [3:0] FIRST_DATA    = 4'd1;
    localparam logic [3:0] LAST_DATA     = 4'd8;
    localparam logic [9:0] GAP_MAX       = 10'd1023;

    // Scan codes with a meaning of their own (set 2)
    localparam logic [7:0] CODE_NONE    = 8'h00;
    localparam logic [7:0] CODE_BREAK   = 8'hF0;
    localparam logic [7:0] CODE_EXT     = 8'hE0;
    localparam logic [7:0] CODE_SHIFT_L = 8'h12;
    localparam logic [7:0] CODE_SHIFT_R = 8'h59;
    localparam logic [7:0] CODE_ALTGR   = 8'h11;
    localparam logic [7:0] CODE_CTRL    = 8'h14;

    // Bit positions in the modifier flags
    localparam int MOD_SHIFT_L = 0;
    localparam int MOD_SHIFT_R = 1;
    localparam int MOD_ALTGR   = 2;
    localparam int MOD_CTRL    = 3;

    // Finished byte from the frame receiver
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } byte_t;

    // Decoded key event
    typedef struct packed {
        logic       emit;
        logic [9:0] code;
        logic       released;
    } key_t;

endpackage

// File: design/ps2kbd_ifs.sv
// Valid/ready channel interfaces of the PS/2 keyboard decoder.

// Input events: falling clock edge with data bit, or millisecond tick
interface ps2kbd_evt_if;
    logic valid;
    logic ready;
    logic cmd;
    logic data_bit;
    modport source (output valid, output cmd, output data_bit, input ready);
    modport sink   (input valid, input cmd, input data_bit, output ready);
endinterface

// Key events out
interface ps2kbd_key_if;
    logic       valid;
    logic       ready;
    logic [9:0] key_code;
    logic       released;
    modport source (output valid, output key_code, output released, input ready);
    modport sink   (input valid, input key_code, input released, output ready);
endinterface

// Timeout register write channel
interface ps2kbd_cfg_if;
    logic       valid;
    logic       ready;
    logic [9:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/ps2kbd_decode.sv
// Scan-code decoder: prefix and modifier flags, key code offset.
module ps2kbd_decode #(
    parameter int KEYMAP_SIZE = 136
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  ps2kbd_pkg::byte_t   rx_byte,
    output ps2kbd_pkg::key_t    key
);

    localparam logic [9:0] OFS_SHIFT = 10'(KEYMAP_SIZE);
    localparam logic [9:0] OFS_ALTGR = 10'(2 * KEYMAP_SIZE);
    localparam logic [9:0] OFS_CTRL  = 10'(3 * KEYMAP_SIZE);
    localparam logic [8:0] MAP_LIMIT = 9'(KEYMAP_SIZE);

    logic       break_reg, break_next;
    logic       ext_reg, ext_next;
    logic [3:0] mod_reg, mod_next;
    logic [3:0] mod_bit;
    logic [7:0] s;

    assign s = rx_byte.data;

    // Decode one byte and work out the flag updates
    always_comb
    begin
        break_next   = break_reg;
        ext_next     = ext_reg;
        mod_next     = mod_reg;
        mod_bit      = 4'd0;
        key.emit     = 1'b0;
        key.code     = {2'b00, s};
        key.released = break_reg;

        if (s == ps2kbd_pkg::CODE_SHIFT_L)
            mod_bit[ps2kbd_pkg::MOD_SHIFT_L] = 1'b1;
        else if (s == ps2kbd_pkg::CODE_SHIFT_R)
            mod_bit[ps2kbd_pkg::MOD_SHIFT_R] = 1'b1;
        else if (s == ps2kbd_pkg::CODE_ALTGR && ext_reg)
            mod_bit[ps2kbd_pkg::MOD_ALTGR] = 1'b1;
        else if (s == ps2kbd_pkg::CODE_CTRL)
            mod_bit[ps2kbd_pkg::MOD_CTRL] = 1'b1;

        if (rx_byte.valid && s != ps2kbd_pkg::CODE_NONE)
        begin
            if (s == ps2kbd_pkg::CODE_BREAK)
            begin
                break_next = 1'b1;
            end
            else if (s == ps2kbd_pkg::CODE_EXT)
            begin
                ext_next = 1'b1;
            end
            else
            begin
                break_next = 1'b0;
                ext_next   = 1'b0;
                if (mod_bit != 4'd0)
                begin
                    // Modifier: update the flag, emit the raw code
                    mod_next = break_reg ? (mod_reg & ~mod_bit) : (mod_reg | mod_bit);
                    key.emit = 1'b1;
                end
                else if ({1'b0, s} < MAP_LIMIT)
                begin
                    key.emit = 1'b1;
                    if (mod_reg[ps2kbd_pkg::MOD_CTRL])
                        key.code = {2'b00, s} + OFS_CTRL;
                    else if (mod_reg[ps2kbd_pkg::MOD_ALTGR])
                        key.code = {2'b00, s} + OFS_ALTGR;
                    else if (mod_reg[ps2kbd_pkg::MOD_SHIFT_L] ||
                             mod_reg[ps2kbd_pkg::MOD_SHIFT_R])
                        key.code = {2'b00, s} + OFS_SHIFT;
                end
            end
        end
    end

    // Hold the flags until a byte is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            break_reg <= 1'b0;
            ext_reg   <= 1'b0;
            mod_reg   <= 4'd0;
        end
        else if (step)
        begin
            break_reg <= break_next;
            ext_reg   <= ext_next;
            mod_reg   <= mod_next;
        end
    end

endmodule

// File: design/ps2_keyboard_frame_and_key_decoder.sv
// Top level: PS/2 frame receiver, scan-code decoder and key output register.
//
//   channel | dir | payload               | item
//   --------+-----+-----------------------+--------------------------------
//   cfg     | in  | data[9:0]             | timeout_ms write
//   evt     | in  | cmd, data_bit         | clock edge or millisecond tick
//   key     | out | key_code[9:0], released | decoded key event
//
// One event is taken per cycle while evt.ready is high; a key event shows
// on key in the cycle after the eleventh edge of its frame is taken. The
// key output register is the only buffer: evt stalls only while a key item
// waits and key.ready is low. Reset clears frame state, flags and the
// output valid, and loads the timeout with 250. cfg is always ready.
module ps2_keyboard_frame_and_key_decoder #(
    parameter int KEYMAP_SIZE = 136
) (
    input logic               clk,
    input logic               rst_n,
    ps2kbd_cfg_if.sink        cfg,
    ps2kbd_evt_if.sink        evt,
    ps2kbd_key_if.source      key
);

    logic [9:0] timeout_reg;
    logic [3:0] edge_count_reg, edge_count_next;
    logic [7:0] frame_bits_reg, frame_bits_next;
    logic [9:0] gap_reg, gap_next;
    logic       out_valid_reg, out_valid_next;
    logic [9:0] out_code_reg;
    logic       out_released_reg;
    logic       accept;
    logic [3:0] ec;
    logic [3:0] ec_inc;
    logic [7:0] fb;
    ps2kbd_pkg::byte_t rx_byte;
    ps2kbd_pkg::key_t  dec_key;

    assign cfg.ready = 1'b1;
    assign evt.ready = !out_valid_reg || key.ready;
    assign accept    = evt.valid && evt.ready;

    // Write the timeout register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            timeout_reg <= ps2kbd_pkg::TIMEOUT_RESET;
        else if (cfg.valid)
            timeout_reg <= cfg.data;
    end

    // Collect frame bits, track the idle gap
    always_comb
    begin
        edge_count_next = edge_count_reg;
        frame_bits_next = frame_bits_reg;
        gap_next        = gap_reg;
        rx_byte.valid   = 1'b0;
        ec              = edge_count_reg;
        fb              = frame_bits_reg;
        if (gap_reg > timeout_reg)
        begin
            ec = 4'd0;
            fb = 8'd0;
        end
        if (ec >= ps2kbd_pkg::FIRST_DATA && ec <= ps2kbd_pkg::LAST_DATA)
            fb[3'(ec - ps2kbd_pkg::FIRST_DATA)] = evt.data_bit;
        ec_inc       = ec + 4'd1;
        rx_byte.data = fb;

        if (accept)
        begin
            if (evt.cmd == ps2kbd_pkg::CMD_TICK)
            begin
                if (gap_reg < ps2kbd_pkg::GAP_MAX)
                    gap_next = gap_reg + 10'd1;
            end
            else
            begin
                gap_next = 10'd0;
                if (ec_inc >= ps2kbd_pkg::FRAME_EDGES)
                begin
                    rx_byte.valid   = 1'b1;
                    edge_count_next = 4'd0;
                    frame_bits_next = 8'd0;
                end
                else
                begin
                    edge_count_next = ec_inc;
                    frame_bits_next = fb;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_count_reg <= 4'd0;
            frame_bits_reg <= 8'd0;
            gap_reg        <= 10'd0;
        end
        else
        begin
            edge_count_reg <= edge_count_next;
            frame_bits_reg <= frame_bits_next;
            gap_reg        <= gap_next;
        end
    end

    ps2kbd_decode #(
        .KEYMAP_SIZE (KEYMAP_SIZE)
    ) u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (rx_byte.valid),
        .rx_byte (rx_byte),
        .key     (dec_key)
    );

    // Load or drop the output item
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
            out_valid_next = rx_byte.valid && dec_key.emit;
        else if (key.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept && rx_byte.valid && dec_key.emit)
        begin
            out_code_reg     <= dec_key.code;
            out_released_reg <= dec_key.released;
        end
    end

    assign key.valid    = out_valid_reg;
    assign key.key_code = out_code_reg;
    assign key.released = out_released_reg;

endmodule
